// ----- hw/rtl/token_bucket_window_rate_limiter_unit_defines.svh -----
// Assertion macros shared by the rate limiter RTL.
// Included by every module that carries concurrent assertions.
`ifndef TOKEN_BUCKET_WINDOW_RATE_LIMITER_UNIT_DEFINES_SVH
`define TOKEN_BUCKET_WINDOW_RATE_LIMITER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define TBW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Checked property that also holds during reset.
`define TBW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TBW_ASSERT(lbl, clk, rstn, prop)
`define TBW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hw/rtl/tbw_pkg.sv -----
// Package for the token bucket rate limiter: widths, constants and types.
// No dependencies; used by tbw_div and the top level.
`timescale 1ns / 1ps
package tbw_pkg;

  localparam int NumKeysDefault = 16;

  // Field widths.
  localparam int KeyW    = 4;
  localparam int EstW    = 16;
  localparam int TimeW   = 48;
  localparam int RetryW  = 26;
  localparam int RemW    = 32;
  localparam int ReqCntW = 32;
  localparam int TokCntW = 40;
  localparam int LevelW  = 30;
  localparam int RateW   = 20;
  localparam int NeedW   = 26;
  localparam int RelW    = 31;
  localparam int ProdW   = RelW + RateW;
  localparam int WelW    = 16;

  // Shared divider geometry.
  localparam int DivNW   = LevelW;
  localparam int DivDW   = RateW;
  localparam int DivCntW = $clog2(DivNW);

  // Reciprocal of 1000 for turning milli-tokens into whole tokens.
  localparam int RecipW     = 29;
  localparam int RecipShift = 38;
  localparam int MulW       = LevelW + RecipW;

  // Behavioral constants.
  localparam logic [WelW-1:0]   WindowMs      = 16'd60000;
  localparam logic [RateW-1:0]  DefaultRate   = 20'd1000;
  localparam logic [LevelW-1:0] DefaultLevel  = 30'd1000000;
  localparam logic [RemW-1:0]   NoLimitRem    = 32'd999;
  localparam logic [RemW-1:0]   UnarmedRem    = 32'd1000;
  localparam logic [9:0]        MilliPerToken = 10'd1000;
  localparam logic [TimeW-1:0]  RelLimit      = 48'd1073741824;
  localparam logic [RecipW-1:0] Recip1000     = 29'd274877907;

  typedef enum logic [1:0] {
    REQ_ALLOW = 2'd0,
    REQ_SET   = 2'd1,
    REQ_RESET = 2'd2,
    REQ_USAGE = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_MAX_REQ = 2'd0,
    CFG_MAX_TOK = 2'd1,
    CFG_RATE    = 2'd2,
    CFG_BURST   = 2'd3
  } cfg_index_e;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_WIN   = 10'b0000000010,
    ST_LIM   = 10'b0000000100,
    ST_REL   = 10'b0000001000,
    ST_MUL   = 10'b0000010000,
    ST_ADD   = 10'b0000100000,
    ST_SPEND = 10'b0001000000,
    ST_DIV1  = 10'b0010000000,
    ST_CNT   = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_e;

  // One bucket table entry.
  typedef struct packed {
    logic [LevelW-1:0]  lvl;
    logic [TimeW-1:0]   lr;
    logic [TimeW-1:0]   ws;
    logic [ReqCntW-1:0] rc;
    logic [TokCntW-1:0] tc;
  } entry_t;

  // Control and status between the sequencer and the divider.
  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivNW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hw/rtl/token_bucket_window_rate_limiter_unit.sv -----
// Top level of the token bucket rate limiter with a 60000 ms fixed window.
// Depends on tbw_pkg, tbw_div and the assertion macro header.
//
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_stall_o   req_type, key_index, token_estimate, now_ms
// out      output     out_valid_o/out_stall_i allowed, retry_after_ms, remaining, usage counts
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// From accept, set, reset, usage and unarmed requests pass WIN and DONE, a window denial
// WIN, LIM and DONE, an admitted allow WIN, LIM, then REL, MUL, ADD and SPEND if a burst
// is set, then CNT and DONE. A bucket denial runs the shared 30-step restoring divider once.
// The input stalls from accept until the result is loaded; the next item can follow in the
// cycle after the load. The slot table has no clearing pass; only armed flags are reset.
// A new transaction is taken while a result waits; the next result waits in DONE.
`timescale 1ns / 1ps
`include "token_bucket_window_rate_limiter_unit_defines.svh"
module token_bucket_window_rate_limiter_unit #(
  parameter int NUM_KEYS = tbw_pkg::NumKeysDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic [tbw_pkg::KeyW-1:0]     key_index_i,
  input  logic [tbw_pkg::EstW-1:0]     token_estimate_i,
  input  logic [tbw_pkg::TimeW-1:0]    now_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         allowed_o,
  output logic [tbw_pkg::RetryW-1:0]   retry_after_ms_o,
  output logic [tbw_pkg::RemW-1:0]     remaining_o,
  output logic [tbw_pkg::ReqCntW-1:0]  requests_in_window_o,
  output logic [tbw_pkg::TokCntW-1:0]  tokens_in_window_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  import tbw_pkg::*;

  // Only slots the key field can reach are stored.
  localparam int SlotDepth = (NUM_KEYS < (1 << KeyW)) ? NUM_KEYS : (1 << KeyW);
  localparam int IdxW      = (SlotDepth > 1) ? $clog2(SlotDepth) : 1;

  // Configuration registers.
  logic [31:0]      max_req_q, max_tok_q;
  logic [RateW-1:0] rate_cfg_q, burst_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q  <= '0;
      max_tok_q  <= '0;
      rate_cfg_q <= '0;
      burst_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_MAX_REQ: max_req_q  <= cfg_data_i;
        CFG_MAX_TOK: max_tok_q  <= cfg_data_i;
        CFG_RATE:    rate_cfg_q <= cfg_data_i[RateW-1:0];
        CFG_BURST:   burst_q    <= cfg_data_i[RateW-1:0];
        default:     max_req_q  <= max_req_q;
      endcase
    end
  end

  // Sequencer and working registers.
  state_e             state_q, state_d;
  logic               in_acc;
  req_type_e          type_q;
  logic               key_ok_q, armed_q, wb_q, wb_d;
  logic [IdxW-1:0]    idx_q, in_idx;
  logic               in_key_ok;
  logic [EstW-1:0]    est_q;
  logic [TimeW-1:0]   now_q;
  entry_t             rd_q, work_q, work_d, arm_entry;
  logic [WelW-1:0]    wel_q, wel_d;
  logic [RelW-1:0]    rel_q, rel_d;
  logic               rel_big_q, rel_big_d;
  logic [LevelW-1:0]  cap_q, cap_d;
  logic [NeedW-1:0]   need_q, need_d;
  logic [RateW-1:0]   rate_q, rate_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic               res_allowed_q, res_allowed_d;
  logic [RetryW-1:0]  res_retry_q, res_retry_d;
  logic [RemW-1:0]    res_rem_q, res_rem_d;
  logic [ReqCntW-1:0] res_ureq_q, res_ureq_d;
  logic [TokCntW-1:0] res_utok_q, res_utok_d;
  logic               out_valid_q;
  logic               out_load;
  logic [SlotDepth-1:0] armed_bits_q;
  logic               arm_now;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Elapsed-time and arithmetic helpers.
  logic [TimeW-1:0]   win_el, rel_el;
  logic               win_expired;
  logic [ProdW:0]     lvl_sum;
  logic [LevelW-1:0]  lvl_new;
  logic [ReqCntW-1:0] rc_new;
  logic [TokCntW:0]   tc_sum;
  logic               lim_deny;
  logic [MulW-1:0]    lvl_recip;

  assign in_key_ok  = 32'(key_index_i) < 32'(NUM_KEYS);
  assign in_idx     = in_key_ok ? key_index_i[IdxW-1:0] : '0;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign win_el      = (now_q >= rd_q.ws) ? (now_q - rd_q.ws) : '0;
  assign win_expired = win_el >= TimeW'(WindowMs);
  assign rel_el      = (now_q >= work_q.lr) ? (now_q - work_q.lr) : '0;
  assign lvl_sum     = (ProdW + 1)'(work_q.lvl) + (ProdW + 1)'(prod_q);
  assign rc_new      = (work_q.rc == '1) ? work_q.rc : work_q.rc + 1'b1;
  assign tc_sum      = (TokCntW + 1)'(work_q.tc) + (TokCntW + 1)'(est_q);

  // Level in whole tokens by reciprocal multiplication; exact for any level below 2^32.
  assign lvl_recip = {{RecipW{1'b0}}, work_q.lvl} * {{LevelW{1'b0}}, Recip1000};

  // Arming loads a full bucket and opens a fresh window.
  always_comb begin
    arm_entry.lvl = (burst_q != '0) ? LevelW'(burst_q * MilliPerToken) : DefaultLevel;
    arm_entry.lr  = now_q;
    arm_entry.ws  = now_q;
    arm_entry.rc  = '0;
    arm_entry.tc  = '0;
  end

  // Window limits on the (possibly restarted) window.
  assign lim_deny = ((max_req_q != '0) && (work_q.rc >= max_req_q)) ||
                    ((max_tok_q != '0) && (tc_sum > (TokCntW + 1)'(max_tok_q)));

  // Refilled level, capped at the burst size.
  always_comb begin
    if (rel_big_q || (lvl_sum > (ProdW + 1)'(cap_q))) begin
      lvl_new = cap_q;
    end else begin
      lvl_new = lvl_sum[LevelW-1:0];
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Next-state and datapath sequencing.
  always_comb begin
    state_d       = state_q;
    work_d        = work_q;
    wb_d          = wb_q;
    wel_d         = wel_q;
    rel_d         = rel_q;
    rel_big_d     = rel_big_q;
    cap_d         = cap_q;
    need_d        = need_q;
    rate_d        = rate_q;
    prod_d        = prod_q;
    res_allowed_d = res_allowed_q;
    res_retry_d   = res_retry_q;
    res_rem_d     = res_rem_q;
    res_ureq_d    = res_ureq_q;
    res_utok_d    = res_utok_q;
    arm_now       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = LevelW'(need_q) - work_q.lvl;
    div_req.divisor  = rate_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d       = ST_WIN;
          wb_d          = 1'b0;
          res_allowed_d = 1'b1;
          res_retry_d   = '0;
          res_rem_d     = '0;
          res_ureq_d    = '0;
          res_utok_d    = '0;
        end
      end
      ST_WIN: begin
        work_d  = rd_q;
        wel_d   = win_expired ? '0 : win_el[WelW-1:0];
        state_d = ST_DONE;
        case (type_q)
          REQ_ALLOW: begin
            if (!armed_q) begin
              res_rem_d = UnarmedRem;
            end else begin
              wb_d    = 1'b1;
              state_d = ST_LIM;
              if (win_expired) begin
                work_d.ws = now_q;
                work_d.rc = '0;
                work_d.tc = '0;
              end
            end
          end
          REQ_SET, REQ_RESET: begin
            if ((type_q == REQ_SET) ? key_ok_q : armed_q) begin
              work_d  = arm_entry;
              wb_d    = 1'b1;
              arm_now = 1'b1;
            end
          end
          default: begin
            if (armed_q && !win_expired) begin
              res_ureq_d = rd_q.rc;
              res_utok_d = rd_q.tc;
            end
          end
        endcase
      end
      ST_LIM: begin
        if (lim_deny) begin
          res_allowed_d = 1'b0;
          res_retry_d   = RetryW'(WindowMs - wel_q);
          state_d       = ST_DONE;
        end else if (burst_q != '0) begin
          state_d = ST_REL;
        end else begin
          state_d = ST_CNT;
        end
      end
      ST_REL: begin
        rel_d     = rel_el[RelW-1:0];
        rel_big_d = rel_el > RelLimit;
        cap_d     = LevelW'(burst_q * MilliPerToken);
        need_d    = NeedW'(est_q * MilliPerToken);
        rate_d    = (rate_cfg_q != '0) ? rate_cfg_q : DefaultRate;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = ProdW'(rel_q) * ProdW'(rate_q);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        work_d.lvl = lvl_new;
        work_d.lr  = now_q;
        state_d    = ST_SPEND;
      end
      ST_SPEND: begin
        if (work_q.lvl < LevelW'(need_q)) begin
          res_allowed_d = 1'b0;
          res_rem_d     = RemW'(lvl_recip[MulW-1:RecipShift]);
          div_req.start = 1'b1;
          state_d       = ST_DIV1;
        end else begin
          work_d.lvl = work_q.lvl - LevelW'(need_q);
          state_d    = ST_CNT;
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          res_retry_d = div_rsp.quotient[RetryW-1:0];
          state_d     = ST_DONE;
        end
      end
      ST_CNT: begin
        work_d.rc = rc_new;
        work_d.tc = tc_sum[TokCntW] ? '1 : tc_sum[TokCntW-1:0];
        res_rem_d = (max_req_q != '0) ? (max_req_q - rc_new) : NoLimitRem;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wb_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      armed_bits_q <= '0;
    end else begin
      state_q <= state_d;
      wb_q    <= wb_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (arm_now) begin
        armed_bits_q[idx_q] <= 1'b1;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      type_q   <= req_type_e'(req_type_i);
      key_ok_q <= in_key_ok;
      idx_q    <= in_idx;
      est_q    <= token_estimate_i;
      now_q    <= now_ms_i;
      armed_q  <= in_key_ok && armed_bits_q[in_idx];
    end
    work_q        <= work_d;
    wel_q         <= wel_d;
    rel_q         <= rel_d;
    rel_big_q     <= rel_big_d;
    cap_q         <= cap_d;
    need_q        <= need_d;
    rate_q        <= rate_d;
    prod_q        <= prod_d;
    res_allowed_q <= res_allowed_d;
    res_retry_q   <= res_retry_d;
    res_rem_q     <= res_rem_d;
    res_ureq_q    <= res_ureq_d;
    res_utok_q    <= res_utok_d;
    if (out_load) begin
      allowed_o            <= res_allowed_q;
      retry_after_ms_o     <= res_retry_q;
      remaining_o          <= res_rem_q;
      requests_in_window_o <= res_ureq_q;
      tokens_in_window_o   <= res_utok_q;
    end
  end

  // Bucket table: one registered read at accept, one write when the result leaves and wb_q is set.
  entry_t slot_mem [SlotDepth];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= slot_mem[in_idx];
    end
    if (out_load && wb_q) begin
      slot_mem[idx_q] <= work_q;
    end
  end

  assign out_valid_o = out_valid_q;

  tbw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  `TBW_ASSERT(a_div_start_free, clk_i, rst_ni, div_req.start |-> !div_rsp.busy)
  `TBW_ASSERT(a_level_capped, clk_i, rst_ni, (state_q == ST_SPEND) |-> (work_q.lvl <= cap_q))
  `TBW_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
  `TBW_ASSERT(a_div_wait, clk_i, rst_ni, (state_q == ST_DIV1) |-> (div_rsp.busy || div_rsp.done))

endmodule

// ----- hw/rtl/tbw_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on tbw_pkg for widths and the request and response structs.
`timescale 1ns / 1ps
module tbw_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbw_pkg::div_req_t req_i,
  output tbw_pkg::div_rsp_t rsp_o
);
  import tbw_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivDW-1:0]   rem_q, rem_d;
  logic [DivNW-1:0]   quo_q, quo_d;
  logic [DivDW-1:0]   dsr_q, dsr_d;
  logic [DivDW:0]     trial;

  // One restoring step per cycle; the dividend shifts out as quotient bits shift in.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, quo_q[DivNW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = DivDW'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[DivNW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivDW-1:0];
        quo_d = {quo_q[DivNW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivNW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
